// File: rtl/rvcsr_pkg.sv
package rvcsr_pkg;

   // Implementation choices for the legalization rules
   localparam int AsidBits       = 4;
   localparam int AlignClearBits = 1;

   localparam logic [8:0]  AsidMask  = 9'((1 << AsidBits) - 1);
   localparam logic [31:0] AlignMask = 32'((1 << AlignClearBits) - 1);

   // CSR operation codes
   localparam logic [1:0] ModeWrite = 2'd0;
   localparam logic [1:0] ModeSet   = 2'd1;
   localparam logic [1:0] ModeClear = 2'd2;

   // MPP encoding that is reserved and legalizes to user
   localparam logic [1:0] MppReserved = 2'd2;
   localparam logic [1:0] MppUser     = 2'd0;

   // Address field that marks a read-only CSR
   localparam logic [1:0] ReadOnlyCode = 2'd3;

   // Implemented CSR numbers
   localparam logic [11:0] AddrMstatus  = 12'h300;
   localparam logic [11:0] AddrMstatush = 12'h310;
   localparam logic [11:0] AddrMtvec    = 12'h305;
   localparam logic [11:0] AddrMepc     = 12'h341;
   localparam logic [11:0] AddrMcause   = 12'h342;
   localparam logic [11:0] AddrMtval    = 12'h343;
   localparam logic [11:0] AddrSatp     = 12'h180;

   typedef struct packed {
      logic [1:0]  mode;
      logic [11:0] csr_address;
      logic [31:0] operand_value;
      logic [1:0]  current_privilege;
      logic [31:0] instruction_word;
   } req_item_type;

   typedef struct packed {
      logic [31:0] read_value;
      logic        illegal_access;
      logic [31:0] trap_info;
   } rsp_item_type;

   // Handshake between the input stage and the execute step
   typedef struct packed {
      logic valid;
      logic advance;
   } stage_ctrl_type;

endpackage

// File: rtl/rv32_machine_csr_file.sv
// RV32 machine CSR file.
// Request channel (req_): one item is one CSR instruction with its mode,
// address, operand, current privilege and raw encoding. It is taken at a
// rising edge with req_valid high and req_stall low.
// Response channel (rsp_): one item per request, in order, carrying the old
// CSR value, an illegal-instruction flag and the trap value.
// A request passes through the input register, then the result register.
// One item per cycle while rsp_stall is low; the read-modify-write of the
// register state sits between the two registers, so each item sees every
// earlier write.
// State is written when an item moves into the result register; an illegal
// access writes nothing.
// Reset clears both stage valids and all CSRs to zero.
// When rsp_stall is held, the result register keeps its item, the input
// register fills and then req_stall rises; no item is dropped.
module rv32_machine_csr_file (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rvcsr_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rvcsr_pkg::rsp_item_type rsp_item
);
   import rvcsr_pkg::*;

   stage_ctrl_type ctrl;
   req_item_type   exec_item;
   rsp_item_type   exec_result;
   logic           exec_fire;

   logic           rsp_valid_ff, rsp_valid_in;
   rsp_item_type   rsp_item_ff,  rsp_item_in;

   // Result register is free or being emptied this cycle
   assign ctrl.advance = ~rsp_valid_ff | ~rsp_stall;
   assign exec_fire    = ctrl.valid & ctrl.advance;

   rvcsr_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .advance     (ctrl.advance),
      .stage_valid (ctrl.valid),
      .stage_item  (exec_item)
   );

   rvcsr_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .exec_fire   (exec_fire),
      .exec_item   (exec_item),
      .exec_result (exec_result)
   );

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (ctrl.advance) begin
         rsp_valid_in = ctrl.valid;
         rsp_item_in  = exec_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // A stalled input register only waits on a full result register
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (ctrl.valid && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked result");

   // Trap value follows the instruction of the item that went out
   a_trap_value : assert property (@(posedge clock) disable iff (reset)
      (exec_fire && exec_result.illegal_access) |=>
      (rsp_valid && rsp_item.trap_info == $past(exec_item.instruction_word)))
      else $error("trap value does not match the illegal instruction");

   // mtvec mode bits never read back as set
   a_mtvec_aligned : assert property (@(posedge clock) disable iff (reset)
      (exec_fire && exec_item.csr_address == AddrMtvec) |=>
      (rsp_item.read_value[1:0] == 2'b00))
      else $error("mtvec read back with mode bits set");

endmodule

// File: rtl/rvcsr_in_stage.sv
module rvcsr_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rvcsr_pkg::req_item_type req_item,
   input  logic                  advance,
   output logic                  stage_valid,
   output rvcsr_pkg::req_item_type stage_item
);
   import rvcsr_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff,  item_in;
   logic         take;

   // Full register that is not moving on holds off the sender
   assign req_stall = valid_ff & ~advance;
   assign take      = req_valid & ~req_stall;

   // Next state of the input register
   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign stage_valid = valid_ff;
   assign stage_item  = item_ff;

endmodule

// File: rtl/rvcsr_regs.sv
module rvcsr_regs (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  exec_fire,
   input  rvcsr_pkg::req_item_type exec_item,
   output rvcsr_pkg::rsp_item_type exec_result
);
   import rvcsr_pkg::*;

   logic [63:0] mstatus_ff, mstatus_in;
   logic [31:0] mtvec_ff,   mtvec_in;
   logic [31:0] mepc_ff,    mepc_in;
   logic [31:0] mcause_ff,  mcause_in;
   logic [31:0] mtval_ff,   mtval_in;
   logic [31:0] satp_ff,    satp_in;

   logic [31:0] old_value;
   logic        known;
   logic        read_only;
   logic        writes;
   logic        illegal;
   logic [31:0] new_value;
   logic        csr_write_en;

   // Read mux and decode of implemented addresses
   always_comb begin
      known     = 1'b1;
      old_value = '0;
      case (exec_item.csr_address)
         AddrMstatus:  old_value = mstatus_ff[31:0];
         AddrMstatush: old_value = mstatus_ff[63:32];
         AddrMtvec:    old_value = mtvec_ff;
         AddrMepc:     old_value = mepc_ff;
         AddrMcause:   old_value = mcause_ff;
         AddrMtval:    old_value = mtval_ff;
         AddrSatp:     old_value = satp_ff;
         default:      known     = 1'b0;
      endcase
   end

   // Access checks; the undefined fourth mode only reads
   assign read_only = exec_item.csr_address[11:10] == ReadOnlyCode;
   assign writes    = (exec_item.mode == ModeWrite) ||
                      (((exec_item.mode == ModeSet) || (exec_item.mode == ModeClear)) &&
                       (exec_item.operand_value != '0));
   assign illegal   = (exec_item.current_privilege < exec_item.csr_address[9:8]) ||
                      (read_only && writes) || !known;

   // Read-modify-write value
   always_comb begin
      case (exec_item.mode)
         ModeWrite: new_value = exec_item.operand_value;
         ModeSet:   new_value = old_value | exec_item.operand_value;
         default:   new_value = old_value & ~exec_item.operand_value;
      endcase
   end

   assign csr_write_en = exec_fire & writes & ~illegal;

   // Legalized register updates
   always_comb begin
      mstatus_in = mstatus_ff;
      mtvec_in   = mtvec_ff;
      mepc_in    = mepc_ff;
      mcause_in  = mcause_ff;
      mtval_in   = mtval_ff;
      satp_in    = satp_ff;
      if (csr_write_en) begin
         case (exec_item.csr_address)
            AddrMstatus: begin
               mstatus_in[31:0] = new_value;
               if (new_value[12:11] == MppReserved) begin
                  mstatus_in[12:11] = MppUser;
               end
            end
            AddrMstatush: mstatus_in[63:32] = new_value;
            AddrMtvec:    mtvec_in  = {new_value[31:2], 2'b00};
            AddrMepc:     mepc_in   = new_value & ~AlignMask;
            AddrMcause:   mcause_in = new_value;
            AddrMtval:    mtval_in  = new_value;
            AddrSatp:     satp_in   = {new_value[31], new_value[30:22] & AsidMask,
                                       new_value[21:0]};
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mstatus_ff <= '0;
         mtvec_ff   <= '0;
         mepc_ff    <= '0;
         mcause_ff  <= '0;
         mtval_ff   <= '0;
         satp_ff    <= '0;
      end else begin
         mstatus_ff <= mstatus_in;
         mtvec_ff   <= mtvec_in;
         mepc_ff    <= mepc_in;
         mcause_ff  <= mcause_in;
         mtval_ff   <= mtval_in;
         satp_ff    <= satp_in;
      end
   end

   // Result of this access
   assign exec_result.read_value     = illegal ? '0 : old_value;
   assign exec_result.illegal_access = illegal;
   assign exec_result.trap_info      = illegal ? exec_item.instruction_word : '0;

endmodule
